### rtl/bqlp_pkg.sv
// Shared widths, register indexes, command codes and control structs for the
// direct-form-II low-pass biquad. No dependencies; every other file uses it.

package bqlp_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int COEF_FRAC_BITS = 14;
	localparam int COEF_W         = 18;
	localparam int DELAY_W        = 24;
	localparam int NUM_COEFS      = 5;
	localparam int CFG_IDX_W      = 3;

	localparam int PROD_W    = COEF_W + DELAY_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int RND_W     = ACC_W - COEF_FRAC_BITS;
	localparam int WF_W      = RND_W + 1;
	localparam int SUM_W     = COEF_W + 2;
	localparam int NUM_W     = SAMPLE_W + COEF_FRAC_BITS + 1;
	localparam int DEN_W     = SUM_W + 1;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);

	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS);
	localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

	localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

	localparam logic [2:0] MUL_NONE  = 3'd0;
	localparam logic [2:0] MUL_A1_D1 = 3'd1;
	localparam logic [2:0] MUL_A2_D2 = 3'd2;
	localparam logic [2:0] MUL_B0_W  = 3'd3;
	localparam logic [2:0] MUL_B1_D1 = 3'd4;
	localparam logic [2:0] MUL_B2_D2 = 3'd5;

	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	typedef struct packed {
		logic       x_load;
		logic [2:0] mul_sel;
		logic [1:0] acc_op;
		logic       w_load;
		logic       div_start;
		logic       div_step;
		logic       preload;
		logic       y_load;
	} bqlp_cmd_t;

	typedef struct packed {
		logic div_done;
	} bqlp_sts_t;

endpackage

### rtl/bqlp_if.sv
// Valid/ready channel interfaces for request and result transactions.
// Depends on bqlp_pkg for the payload widths.

interface bqlp_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 req_type;
	logic signed [bqlp_pkg::SAMPLE_W-1:0] sample_in;

	modport source (output valid, output req_type, output sample_in, input ready);
	modport sink (input valid, input req_type, input sample_in, output ready);
endinterface

interface bqlp_res_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [bqlp_pkg::SAMPLE_W-1:0] filtered_out;

	modport source (output valid, output filtered_out, input ready);
	modport sink (input valid, input filtered_out, output ready);
endinterface

### rtl/bqlp_datapath.sv
// Datapath: coefficient registers, delay line, shared multiplier with
// accumulator, bit-serial preload divider and output register. Uses bqlp_pkg.

module bqlp_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bqlp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bqlp_pkg::COEF_W-1:0]          cfg_data,
	input  logic signed [bqlp_pkg::SAMPLE_W-1:0] sample_in,
	input  bqlp_pkg::bqlp_cmd_t                  cmd,
	output bqlp_pkg::bqlp_sts_t                  sts,
	output logic signed [bqlp_pkg::SAMPLE_W-1:0] filtered_out
);
	import bqlp_pkg::*;

	logic signed [COEF_W-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [DELAY_W-1:0]  d1_q, d2_q, w_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] y_q;

	logic signed [COEF_W-1:0]   mul_c;
	logic signed [DELAY_W-1:0]  mul_d;
	logic signed [DELAY_W-1:0]  x_ext;
	logic signed [ACC_W-1:0]    acc_biased;
	logic signed [ACC_W-1:0]    acc_shifted;
	logic signed [RND_W-1:0]    rnd;
	logic signed [WF_W-1:0]     w_full;
	logic                       w_ok;
	logic signed [SAMPLE_W-1:0] y_sat;

	logic [NUM_W-1:0]     num_q, quo_q;
	logic [DEN_W-1:0]     den_q, rem_q;
	logic                 neg_q, zero_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic signed [SUM_W-1:0] coef_sum;
	logic [SUM_W-1:0]     abs_sum;
	logic [SAMPLE_W-1:0]  abs_x;
	logic [DEN_W:0]       trial;
	logic                 q_ok;
	logic [DELAY_W-1:0]   q_lo;
	logic signed [DELAY_W-1:0] pre_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= COEF_ONE;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_B0:  b0_q <= cfg_data;
				REG_B1:  b1_q <= cfg_data;
				REG_B2:  b2_q <= cfg_data;
				REG_A1:  a1_q <= cfg_data;
				REG_A2:  a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign x_ext = {{(DELAY_W - SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};

	always_comb begin
		case (cmd.mul_sel)
			MUL_A1_D1: begin mul_c = a1_q; mul_d = d1_q; end
			MUL_A2_D2: begin mul_c = a2_q; mul_d = d2_q; end
			MUL_B0_W:  begin mul_c = b0_q; mul_d = w_q;  end
			MUL_B1_D1: begin mul_c = b1_q; mul_d = d1_q; end
			MUL_B2_D2: begin mul_c = b2_q; mul_d = d2_q; end
			default:   begin mul_c = '0;   mul_d = '0;   end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.x_load) begin
			x_q <= sample_in;
		end
		prod_s1 <= mul_c * mul_d;
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= {{(ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
			ACC_ADD:  acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
			default:  ;
		endcase
		if (cmd.w_load) begin
			w_q <= w_ok ? w_full[DELAY_W-1:0] : x_ext;
		end
		if (cmd.y_load) begin
			y_q <= y_sat;
		end
	end

	// Round to nearest with ties upward, then drop the fraction bits.
	assign acc_biased  = acc_q + RND_HALF;
	assign acc_shifted = acc_biased >>> COEF_FRAC_BITS;
	assign rnd         = acc_shifted[RND_W-1:0];

	assign w_full = {{(WF_W - SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q} - {rnd[RND_W-1], rnd};
	assign w_ok   = (&w_full[WF_W-1:DELAY_W-1]) || ~(|w_full[WF_W-1:DELAY_W-1]);

	always_comb begin
		if ((&rnd[RND_W-1:SAMPLE_W-1]) || ~(|rnd[RND_W-1:SAMPLE_W-1])) begin
			y_sat = rnd[SAMPLE_W-1:0];
		end else if (rnd[RND_W-1]) begin
			y_sat = {1'b1, {(SAMPLE_W - 1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SAMPLE_W - 1){1'b1}}};
		end
	end

	assign filtered_out = y_q;

	// Preload divider: restoring division of 2|x|*2^F + |s| by 2|s|, one bit per cycle.
	assign coef_sum = {{2{b0_q[COEF_W-1]}}, b0_q} + {{2{b1_q[COEF_W-1]}}, b1_q}
		+ {{2{b2_q[COEF_W-1]}}, b2_q};
	assign abs_sum  = coef_sum[SUM_W-1] ? SUM_W'(-coef_sum) : SUM_W'(coef_sum);
	assign abs_x    = x_q[SAMPLE_W-1] ? SAMPLE_W'(-x_q) : SAMPLE_W'(x_q);
	assign trial    = {rem_q, num_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= DIV_CNT_W'(NUM_W);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q  <= {abs_x, {(COEF_FRAC_BITS + 1){1'b0}}} + NUM_W'(abs_sum);
			den_q  <= {abs_sum, 1'b0};
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= x_q[SAMPLE_W-1] ^ coef_sum[SUM_W-1];
			zero_q <= (coef_sum == '0);
		end else if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign q_lo = quo_q[DELAY_W-1:0];
	assign q_ok = ~(|quo_q[NUM_W-1:DELAY_W-1])
		|| (neg_q && (quo_q == (NUM_W'(1) << (DELAY_W - 1))));

	always_comb begin
		if (zero_q || !q_ok) begin
			pre_val = x_ext;
		end else if (neg_q) begin
			pre_val = -q_lo;
		end else begin
			pre_val = q_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (cmd.preload) begin
			d1_q <= pre_val;
			d2_q <= pre_val;
		end else if (cmd.y_load) begin
			d1_q <= w_q;
			d2_q <= d1_q;
		end
	end

	assign sts.div_done = (cnt_q == '0);

endmodule

### rtl/bqlp_ctrl.sv
// Controller state machine: sequences the multiply-accumulate steps and the
// preload division, and owns the channel handshakes. Uses bqlp_pkg.

module bqlp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_type,
	output logic                req_ready,
	output logic                res_valid,
	input  logic                res_ready,
	input  bqlp_pkg::bqlp_sts_t sts,
	output bqlp_pkg::bqlp_cmd_t cmd
);
	import bqlp_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV0 = 4'd1;
	localparam logic [3:0] S_DIV  = 4'd2;
	localparam logic [3:0] S_FB1  = 4'd3;
	localparam logic [3:0] S_FB2  = 4'd4;
	localparam logic [3:0] S_FB3  = 4'd5;
	localparam logic [3:0] S_W    = 4'd6;
	localparam logic [3:0] S_FF0  = 4'd7;
	localparam logic [3:0] S_FF1  = 4'd8;
	localparam logic [3:0] S_FF2  = 4'd9;
	localparam logic [3:0] S_FF3  = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;

	logic [3:0] state_q, state_d;
	logic       res_valid_q;
	logic       out_free;

	assign out_free  = !res_valid_q || res_ready;
	assign req_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.mul_sel   = MUL_NONE;
		cmd.acc_op    = ACC_HOLD;
		unique case (state_q)
			S_IDLE: begin
				cmd.x_load = req_valid;
				if (req_valid) begin
					state_d = req_type ? S_DIV0 : S_FB1;
				end
			end
			S_DIV0: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.preload = 1'b1;
					state_d     = S_FB1;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_FB1: begin
				cmd.mul_sel = MUL_A1_D1;
				state_d     = S_FB2;
			end
			S_FB2: begin
				cmd.mul_sel = MUL_A2_D2;
				cmd.acc_op  = ACC_LOAD;
				state_d     = S_FB3;
			end
			S_FB3: begin
				cmd.acc_op = ACC_ADD;
				state_d    = S_W;
			end
			S_W: begin
				cmd.w_load = 1'b1;
				state_d    = S_FF0;
			end
			S_FF0: begin
				cmd.mul_sel = MUL_B0_W;
				state_d     = S_FF1;
			end
			S_FF1: begin
				cmd.mul_sel = MUL_B1_D1;
				cmd.acc_op  = ACC_LOAD;
				state_d     = S_FF2;
			end
			S_FF2: begin
				cmd.mul_sel = MUL_B2_D2;
				cmd.acc_op  = ACC_ADD;
				state_d     = S_FF3;
			end
			S_FF3: begin
				cmd.acc_op = ACC_ADD;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.y_load = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.y_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/biquad_lowpass_df2_core.sv
// Requests are accepted only while idle; a preload request first runs the division.
// Both kinds then run the feedback and feedforward steps; the single shared
// 18x24 multiplier takes five products per sample and the divider one bit a cycle.
// A result waits in the output register while the next request is accepted.
// Reset (arst_n low) clears both delays, sets b0 to 1.0 and the other coefficients to 0.
// Top level of the biquad; uses bqlp_pkg, bqlp_if, bqlp_ctrl and bqlp_datapath.

module biquad_lowpass_df2_core (
	input  logic                           clk,
	input  logic                           arst_n,
	bqlp_req_if.sink                       req,
	bqlp_res_if.source                     res,
	input  logic                           cfg_we,
	input  logic [bqlp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bqlp_pkg::COEF_W-1:0]    cfg_data
);
	import bqlp_pkg::*;

	bqlp_cmd_t cmd;
	bqlp_sts_t sts;

	bqlp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bqlp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_in    (req.sample_in),
		.cmd          (cmd),
		.sts          (sts),
		.filtered_out (res.filtered_out)
	);

endmodule

### rtl/bqlp_checker.sv
// Port-level checks for the biquad top level, attached by a bind statement.
// Depends on bqlp_pkg and biquad_lowpass_df2_core.

module bqlp_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [bqlp_pkg::SAMPLE_W-1:0] out_data
);

	// The block works on one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while the previous one was still in work");

	// A new result appears only at the end of a computation, never from idle.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a request in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before its transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data))
		else $error("stalled result changed");

endmodule

bind biquad_lowpass_df2_core bqlp_checker u_bqlp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_data  (res.filtered_out)
);

### verif/tb_biquad_lowpass_df2_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for biquad_lowpass_df2_core: random and directed requests, a
// fixed-point predictor of the filter, and a result checker. Uses bqlp_pkg and bqlp_if.

module tb_biquad_lowpass_df2_core;
	import bqlp_pkg::*;

	localparam logic REQ_FILTER  = 1'b0;
	localparam logic REQ_PRELOAD = 1'b1;

	localparam int     SAMPLE_HI   = (1 << (SAMPLE_W - 1)) - 1;
	localparam int     SAMPLE_LO   = -(1 << (SAMPLE_W - 1));
	localparam longint DELAY_HI    = (longint'(1) <<< (DELAY_W - 1)) - 1;
	localparam longint DELAY_LO    = -(longint'(1) <<< (DELAY_W - 1));
	localparam int     COEF_HI     = (1 << (COEF_W - 1)) - 1;
	localparam int     COEF_LO     = -(1 << (COEF_W - 1));
	localparam int     UNITY       = 1 << COEF_FRAC_BITS;
	localparam int     LONG_HOLD   = 200;
	localparam int     CYCLE_LIMIT = 1_000_000;
	localparam int     PHASE_ITEMS = 128;

	typedef struct {
		logic                       kind;
		logic signed [SAMPLE_W-1:0] sample;
	} filter_req_t;

	typedef enum logic [1:0] {SINK_STEADY, SINK_COIN, SINK_SPARSE} sink_mode_t;
	typedef enum logic [1:0] {SHAPE_HOLD, SHAPE_NOISE, SHAPE_JITTER, SHAPE_RAIL} sample_shape_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	bqlp_req_if req_ch ();
	bqlp_res_if res_ch ();

	biquad_lowpass_df2_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic signed [COEF_W-1:0]   coef_shadow [NUM_COEFS];
	logic signed [DELAY_W-1:0]  delay_recent;
	logic signed [DELAY_W-1:0]  delay_older;
	logic signed [SAMPLE_W-1:0] expected_filtered [$];
	filter_req_t                pending_reqs [$];

	int          queued_total;
	int          checked_total;
	int          accepted_items;
	int          mismatch_count;
	int          burst_left;
	int          gap_left;
	int          hold_left;
	int          next_hold_at;
	int          mode_left;
	int          cycle_count;
	sink_mode_t  sink_mode;
	logic        sink_take;
	filter_req_t next_req;
	logic signed [SAMPLE_W-1:0] want;

	function automatic longint round_frac(input longint v);
		return (v + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
	endfunction

	function automatic void predict_filter_output(input logic kind,
			input logic signed [SAMPLE_W-1:0] sample);
		longint x, b0, b1, b2, a1, a2, d1, d2, sum, num, un, ud, q, w, y;
		x  = sample;
		b0 = coef_shadow[REG_B0];
		b1 = coef_shadow[REG_B1];
		b2 = coef_shadow[REG_B2];
		a1 = coef_shadow[REG_A1];
		a2 = coef_shadow[REG_A2];
		if (kind == REQ_PRELOAD) begin
			sum = b0 + b1 + b2;
			d1  = x;
			if (sum != 0) begin
				num = x <<< COEF_FRAC_BITS;
				un  = (num < 0) ? -num : num;
				ud  = (sum < 0) ? -sum : sum;
				q   = (2 * un + ud) / (2 * ud);
				if (q <= DELAY_HI + 1) begin
					if ((num < 0) != (sum < 0))
						q = -q;
					if (q >= DELAY_LO && q <= DELAY_HI)
						d1 = q;
				end
			end
			delay_recent = DELAY_W'(d1);
			delay_older  = DELAY_W'(d1);
		end
		d1 = delay_recent;
		d2 = delay_older;
		w  = x - round_frac(a1 * d1 + a2 * d2);
		if (w < DELAY_LO || w > DELAY_HI)
			w = x;
		y = round_frac(b0 * w + b1 * d1 + b2 * d2);
		if (y > SAMPLE_HI)
			y = SAMPLE_HI;
		if (y < SAMPLE_LO)
			y = SAMPLE_LO;
		delay_older  = delay_recent;
		delay_recent = DELAY_W'(w);
		expected_filtered.push_back(SAMPLE_W'(y));
	endfunction

	task automatic queue_req(input logic kind, input int sample);
		filter_req_t item;
		item.kind   = kind;
		item.sample = SAMPLE_W'(sample);
		pending_reqs.push_back(item);
		queued_total++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (checked_total != queued_total)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= COEF_W'(value);
		if (idx < NUM_COEFS)
			coef_shadow[idx] = COEF_W'(value);
	endtask

	task automatic load_coefs(input int b0, input int b1, input int b2, input int a1,
			input int a2);
		wait_idle();
		write_coef(REG_B0, b0);
		write_coef(REG_B1, b1);
		write_coef(REG_B2, b2);
		write_coef(REG_A1, a1);
		write_coef(REG_A2, a2);
		write_coef(CFG_IDX_W'($urandom_range(NUM_COEFS, (1 << CFG_IDX_W) - 1)),
			int'($urandom_range(0, (1 << COEF_W) - 1)) + COEF_LO);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_stable_lowpass();
		int a2, lim, b0;
		a2  = $urandom_range(0, 15000);
		lim = UNITY + a2 - 600;
		b0  = $urandom_range(1, 4096);
		load_coefs(b0, 2 * b0, b0, int'($urandom_range(0, 2 * lim)) - lim, a2);
	endtask

	task automatic load_random_coefs();
		int c [NUM_COEFS];
		foreach (c[i])
			c[i] = int'($urandom_range(0, (1 << COEF_W) - 1)) + COEF_LO;
		load_coefs(c[REG_B0], c[REG_B1], c[REG_B2], c[REG_A1], c[REG_A2]);
	endtask

	// A preload, then segments of held, noisy, jittered or rail-level samples with an occasional preload.
	task automatic queue_random_phase(input int count);
		int            seg_left, level, s;
		sample_shape_t shape;
		seg_left = 0;
		level    = 0;
		shape    = SHAPE_HOLD;
		queue_req(REQ_PRELOAD, int'($urandom_range(0, 65535)) + SAMPLE_LO);
		for (int i = 1; i < count; i++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(1, 32);
				shape    = sample_shape_t'($urandom_range(0, 3));
				level    = int'($urandom_range(0, 65535)) + SAMPLE_LO;
			end
			seg_left--;
			case (shape)
				SHAPE_HOLD:   s = level;
				SHAPE_NOISE:  s = int'($urandom_range(0, 65535)) + SAMPLE_LO;
				SHAPE_JITTER: s = level + int'($urandom_range(0, 512)) - 256;
				default:      s = ($urandom_range(0, 1) != 0) ? SAMPLE_HI : SAMPLE_LO;
			endcase
			if (s > SAMPLE_HI)
				s = SAMPLE_HI;
			if (s < SAMPLE_LO)
				s = SAMPLE_LO;
			queue_req(($urandom_range(0, 15) == 0) ? REQ_PRELOAD : REQ_FILTER, s);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.req_type <= REQ_FILTER;
			req_ch.sample_in <= '0;
			burst_left      <= 0;
			gap_left        <= 0;
			accepted_items  <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predict_filter_output(req_ch.req_type, req_ch.sample_in);
				accepted_items <= accepted_items + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left != 0 || pending_reqs.size() == 0) begin
					req_ch.valid <= 1'b0;
					if (gap_left != 0)
						gap_left <= gap_left - 1;
				end else begin
					next_req = pending_reqs.pop_front();
					req_ch.valid     <= 1'b1;
					req_ch.req_type  <= next_req.kind;
					req_ch.sample_in <= next_req.sample;
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else if ($urandom_range(0, 7) == 0) begin
						burst_left <= 100;
						gap_left   <= 0;
					end else begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= $urandom_range(0, 30);
					end
				end
			end
		end
	end

	// A long receiver hold-off starts each time the accepted transaction count passes a mark.
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left    <= 0;
			next_hold_at <= 300;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (accepted_items >= next_hold_at) begin
			hold_left    <= LONG_HOLD;
			next_hold_at <= next_hold_at + 600;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready   <= 1'b0;
			sink_mode      <= SINK_STEADY;
			mode_left      <= 0;
			checked_total  <= 0;
			mismatch_count <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_filtered.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result transaction: filtered_out %0d",
							res_ch.filtered_out);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_filtered.pop_front();
					checked_total <= checked_total + 1;
					if (res_ch.filtered_out !== want) begin
						if (mismatch_count < 10)
							$display("filtered_out mismatch at result %0d: expected %0d, got %0d",
								checked_total, want, res_ch.filtered_out);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (mode_left == 0) begin
				sink_mode <= sink_mode_t'($urandom_range(0, 2));
				mode_left <= $urandom_range(32, 256);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (sink_mode)
				SINK_STEADY: sink_take = 1'b1;
				SINK_COIN:   sink_take = $urandom_range(0, 1) != 0;
				default:     sink_take = $urandom_range(0, 3) == 0;
			endcase
			res_ch.ready <= (hold_left == 0) && sink_take;
		end
	end

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_FILTER;
		req_ch.sample_in = '0;
		res_ch.ready     = 1'b0;
		cycle_count      = 0;
		queued_total     = 0;
		foreach (coef_shadow[i])
			coef_shadow[i] = '0;
		coef_shadow[REG_B0] = COEF_ONE;
		delay_recent = '0;
		delay_older  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Unity pass-through after reset, rails and alternating bit patterns.
		queue_req(REQ_FILTER, SAMPLE_HI);
		queue_req(REQ_FILTER, SAMPLE_LO);
		queue_req(REQ_PRELOAD, SAMPLE_HI);
		queue_req(REQ_FILTER, 0);
		queue_req(REQ_PRELOAD, SAMPLE_LO);
		queue_req(REQ_FILTER, -1);
		queue_req(REQ_FILTER, 1);
		queue_req(REQ_PRELOAD, 16'sh5555);
		queue_req(REQ_FILTER, int'(16'shAAAA));

		// DC gain of two: odd samples land on half-way preload quotients.
		load_coefs(UNITY, UNITY, 0, 0, 0);
		queue_req(REQ_PRELOAD, 1);
		queue_req(REQ_PRELOAD, -1);
		queue_req(REQ_PRELOAD, 3);
		queue_req(REQ_PRELOAD, -3);
		queue_req(REQ_PRELOAD, SAMPLE_HI);
		queue_req(REQ_PRELOAD, SAMPLE_LO);

		// Tiny gain sum: the preload quotient leaves the delay range, and the strong
		// feedback then overflows the new delay value.
		load_coefs(1, 0, 0, COEF_LO, 0);
		queue_req(REQ_PRELOAD, 511);
		queue_req(REQ_PRELOAD, -512);
		queue_req(REQ_PRELOAD, 512);
		queue_req(REQ_PRELOAD, SAMPLE_LO);
		queue_req(REQ_FILTER, SAMPLE_HI);

		// Gain sum of zero: the preload falls back to the sample itself.
		load_coefs(UNITY, -UNITY, 0, 0, 0);
		queue_req(REQ_PRELOAD, 1234);
		queue_req(REQ_FILTER, -4321);
		queue_req(REQ_FILTER, 0);

		load_stable_lowpass();
		queue_random_phase(PHASE_ITEMS);
		load_coefs(COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI);
		queue_random_phase(PHASE_ITEMS);
		load_stable_lowpass();
		queue_random_phase(PHASE_ITEMS);
		load_coefs(COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO);
		queue_random_phase(PHASE_ITEMS);
		load_coefs(UNITY, -UNITY, 0, -int'($urandom_range(0, UNITY)),
			$urandom_range(0, UNITY / 2));
		queue_random_phase(PHASE_ITEMS);
		load_stable_lowpass();
		queue_random_phase(PHASE_ITEMS);
		load_random_coefs();
		queue_random_phase(PHASE_ITEMS);
		load_coefs(0, 0, 0, 0, 0);
		queue_random_phase(PHASE_ITEMS);
		load_stable_lowpass();
		queue_random_phase(PHASE_ITEMS);
		load_coefs($urandom_range(1, 3), 0, 0, -UNITY, UNITY / 2);
		queue_random_phase(PHASE_ITEMS);
		load_random_coefs();
		queue_random_phase(PHASE_ITEMS);
		load_stable_lowpass();
		queue_random_phase(PHASE_ITEMS);

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_filtered.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
